// File: sv/dtsv_pkg.sv
// ----------------------------------------------------------------------------
// dtsv_pkg - shared definitions of the date and time string validator
// Widths, record layout, character codes, register indexes and small helper
// functions for the YYYY-MM-DD HH:mm:ss checker.
// ----------------------------------------------------------------------------
package dtsv_pkg;

    // record layout
    localparam int REC_LEN = 19;
    localparam int POS_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int DAY_W   = 5;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 8;

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = YEAR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YEAR_LOWEST  = 1'b0,
        CFG_YEAR_HIGHEST = 1'b1
    } cfg_idx_t;

    localparam logic [YEAR_W-1:0] YEAR_LOWEST_RST  = 14'd2000;
    localparam logic [YEAR_W-1:0] YEAR_HIGHEST_RST = 14'd9999;

    // field limits
    localparam logic [FIELD_W-1:0] MONTH_COUNT = 7'd12;
    localparam logic [FIELD_W-1:0] HOUR_LAST   = 7'd23;
    localparam logic [FIELD_W-1:0] MINSEC_MAX  = 7'd59;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

    // what a character position of the record holds
    typedef enum logic [2:0] {
        SLOT_YEAR,
        SLOT_MONTH,
        SLOT_DAY,
        SLOT_HOUR,
        SLOT_MINUTE,
        SLOT_SECOND,
        SLOT_SEP
    } slot_t;

    // position to slot decoder
    function automatic slot_t slot_of(input logic [POS_W-1:0] pos);
        slot_t s;
        unique case (pos) inside
            5'd0, 5'd1, 5'd2, 5'd3: s = SLOT_YEAR;
            5'd5, 5'd6:             s = SLOT_MONTH;
            5'd8, 5'd9:             s = SLOT_DAY;
            5'd11, 5'd12:           s = SLOT_HOUR;
            5'd14, 5'd15:           s = SLOT_MINUTE;
            5'd17, 5'd18:           s = SLOT_SECOND;
            default:                s = SLOT_SEP;
        endcase
        return s;
    endfunction

    // separator expected at a separator position
    function automatic logic [CHAR_W-1:0] sep_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos) inside
            5'd4, 5'd7:   c = CHAR_DASH;
            5'd10:        c = CHAR_SPACE;
            default:      c = CHAR_COLON;
        endcase
        return c;
    endfunction

    // decimal accumulate, times ten plus digit, as shift and add
    function automatic logic [YEAR_W-1:0] push_year(input logic [YEAR_W-1:0] acc,
                                                    input logic [DIGIT_W-1:0] d);
        return (acc << 3) + (acc << 1) + YEAR_W'(d);
    endfunction

    function automatic logic [FIELD_W-1:0] push_field(input logic [FIELD_W-1:0] acc,
                                                      input logic [DIGIT_W-1:0] d);
        return (acc << 3) + (acc << 1) + FIELD_W'(d);
    endfunction

    // days in a month, month already known to be 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [FIELD_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] n;
        unique case (month) inside
            7'd2:                     n = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:  n = 5'd30;
            default:                  n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

// File: sv/datetime_string_validator.sv
// ----------------------------------------------------------------------------
// datetime_string_validator - YYYY-MM-DD HH:mm:ss record checker
// Checks a character stream against the date and time pattern and flags
// whether each record names an existing Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: one character per request, s_tdata holds the character and
//   s_tlast marks a line end (the character is then ignored). A line end
//   closes the record. Output stream: one result per record, m_tdata[0] is
//   the valid flag. A result comes with the 19th character, or with a line
//   end that arrives before it (then invalid). Characters after the 19th
//   are dropped until the line end, which then gives no result.
//   Year limits are set through the write port (index 0 lowest, 1 highest)
//   while the stream is idle.
// Timing
//   One character per cycle sustained while the receiver takes results. A
//   result shows on m_tvalid once the character that causes it has passed
//   through the input register and the check logic has loaded the result
//   register from it; a full, stalled result register holds it back.
// Reset and stall
//   Reset empties both registers, clears the record and loads the year
//   limits 2000 and 9999. While the receiver stalls, the result register
//   holds; characters that give no result keep flowing, and s_tready falls
//   only when a character that gives a result finds the result register full.
// ----------------------------------------------------------------------------
module datetime_string_validator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dtsv_pkg::TDATA_IN_W-1:0]    s_tdata,   // [7:0] char_code
    input  logic                               s_tlast,   // line_end
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dtsv_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [0] valid_res, [7:1] zero
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [dtsv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dtsv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // configuration registers
    logic [dtsv_pkg::YEAR_W-1:0] year_lowest_reg;
    logic [dtsv_pkg::YEAR_W-1:0] year_highest_reg;

    // input register
    logic                          in_valid_reg, in_valid_next;
    logic [dtsv_pkg::CHAR_W-1:0]   in_char_reg;
    logic                          in_last_reg;

    // record state
    logic [dtsv_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                          fmt_ok_reg, fmt_ok_next;
    logic [dtsv_pkg::YEAR_W-1:0]   year_reg, year_next;
    logic [dtsv_pkg::FIELD_W-1:0]  month_reg, month_next;
    logic [dtsv_pkg::FIELD_W-1:0]  day_reg, day_next;
    logic [dtsv_pkg::FIELD_W-1:0]  hour_reg, hour_next;
    logic [dtsv_pkg::FIELD_W-1:0]  minute_reg, minute_next;
    logic [dtsv_pkg::FIELD_W-1:0]  second_reg, second_next;
    logic [dtsv_pkg::DIGIT_W-1:0]  ydig_reg [4];
    logic [dtsv_pkg::DIGIT_W-1:0]  ydig_next [4];

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          out_res_reg, out_res_next;

    // check logic
    logic                          in_fire;
    logic                          process;
    logic                          produce;
    logic                          res_val;
    logic                          rec_done;
    logic                          is_digit;
    logic [dtsv_pkg::DIGIT_W-1:0]  digit;
    dtsv_pkg::slot_t               slot;
    logic                          leap;
    logic [dtsv_pkg::DAY_W-1:0]    day_limit;
    logic [1:0]                    lo_mod4;
    logic [1:0]                    hi_mod4;

    assign in_fire  = s_tvalid && s_tready;
    assign rec_done = (pos_reg == dtsv_pkg::POS_W'(dtsv_pkg::REC_LEN));
    assign is_digit = (in_char_reg >= dtsv_pkg::CHAR_ZERO) &&
                      (in_char_reg <= dtsv_pkg::CHAR_NINE);
    assign digit    = in_char_reg[dtsv_pkg::DIGIT_W-1:0];
    assign slot     = dtsv_pkg::slot_of(pos_reg);

    // item gives a result: early line end, or the last character of the record
    assign produce = in_last_reg ? !rec_done
                                 : (pos_reg == dtsv_pkg::POS_W'(dtsv_pkg::REC_LEN - 1));

    // item leaves the input register unless its result finds the output full and stalled
    assign process  = in_valid_reg && (!produce || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;

    // leap year from the decimal digits: (10a + b) mod 4 = (2a + b) mod 4
    assign lo_mod4 = {ydig_reg[2][0], 1'b0} + ydig_reg[3][1:0];
    assign hi_mod4 = {ydig_reg[0][0], 1'b0} + ydig_reg[1][1:0];
    always_comb begin
        if (ydig_reg[2] == '0 && ydig_reg[3] == '0) begin
            leap = (hi_mod4 == 2'd0);
        end else begin
            leap = (lo_mod4 == 2'd0);
        end
    end

    assign day_limit = dtsv_pkg::month_days(month_reg, leap);

    // record state update for one character
    always_comb begin
        pos_next    = pos_reg;
        fmt_ok_next = fmt_ok_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        ydig_next   = ydig_reg;
        if (in_last_reg) begin
            pos_next    = '0;
            fmt_ok_next = 1'b1;
            year_next   = '0;
            month_next  = '0;
            day_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
        end else if (!rec_done) begin
            pos_next = pos_reg + 1'b1;
            if (slot == dtsv_pkg::SLOT_SEP) begin
                if (in_char_reg != dtsv_pkg::sep_char(pos_reg)) begin
                    fmt_ok_next = 1'b0;
                end
            end else if (!is_digit) begin
                fmt_ok_next = 1'b0;
            end else begin
                case (slot)
                    dtsv_pkg::SLOT_YEAR: begin
                        year_next = dtsv_pkg::push_year(year_reg, digit);
                        ydig_next[pos_reg[1:0]] = digit;
                    end
                    dtsv_pkg::SLOT_MONTH:  month_next  = dtsv_pkg::push_field(month_reg, digit);
                    dtsv_pkg::SLOT_DAY:    day_next    = dtsv_pkg::push_field(day_reg, digit);
                    dtsv_pkg::SLOT_HOUR:   hour_next   = dtsv_pkg::push_field(hour_reg, digit);
                    dtsv_pkg::SLOT_MINUTE: minute_next = dtsv_pkg::push_field(minute_reg, digit);
                    default:               second_next = dtsv_pkg::push_field(second_reg, digit);
                endcase
            end
        end
    end

    // final check, uses the record state after the last character
    always_comb begin
        res_val = fmt_ok_next &&
                  (year_reg >= year_lowest_reg) && (year_reg <= year_highest_reg) &&
                  (month_reg != '0) && (month_reg <= dtsv_pkg::MONTH_COUNT) &&
                  (hour_reg <= dtsv_pkg::HOUR_LAST) &&
                  (minute_reg <= dtsv_pkg::MINSEC_MAX) &&
                  (second_next <= dtsv_pkg::MINSEC_MAX) &&
                  (day_reg != '0) && (day_reg <= dtsv_pkg::FIELD_W'(day_limit));
        if (in_last_reg) begin
            res_val = 1'b0;
        end
    end

    // input and result register control
    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end
        if (process && produce) begin
            out_valid_next = 1'b1;
            out_res_next   = res_val;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_reg          <= '0;
            fmt_ok_reg       <= 1'b1;
            year_reg         <= '0;
            month_reg        <= '0;
            day_reg          <= '0;
            hour_reg         <= '0;
            minute_reg       <= '0;
            second_reg       <= '0;
            year_lowest_reg  <= dtsv_pkg::YEAR_LOWEST_RST;
            year_highest_reg <= dtsv_pkg::YEAR_HIGHEST_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process) begin
                pos_reg    <= pos_next;
                fmt_ok_reg <= fmt_ok_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
            end
            if (cfg_wr_en) begin
                if (cfg_index == dtsv_pkg::CFG_YEAR_LOWEST) begin
                    year_lowest_reg <= cfg_wdata;
                end else begin
                    year_highest_reg <= cfg_wdata;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_char_reg <= s_tdata[dtsv_pkg::CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (process) begin
            ydig_reg <= ydig_next;
        end
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(dtsv_pkg::TDATA_OUT_W-1)'(0), out_res_reg};

endmodule

// File: sv/dtsv_checker.sv
// ----------------------------------------------------------------------------
// dtsv_checker - port level checks of the date and time string validator
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module dtsv_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [dtsv_pkg::TDATA_OUT_W-1:0]   m_tdata
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present right after reset");

    // input backpressure only comes from a stalled full result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    // padding bits of the result stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[dtsv_pkg::TDATA_OUT_W-1:1] == '0))
        else $error("result padding bits not zero");

endmodule

bind datetime_string_validator dtsv_checker u_dtsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/datetime_string_validator_tb.sv
// ----------------------------------------------------------------------------
// datetime_string_validator_tb - self-checking bench of the date/time checker
// Feeds character records, short lines and noise through the input stream,
// predicts the valid flag of every record in the bench (or takes the typed flag
// of a directed row) and compares each result request against it. Random idling
// on both sides, a long receiver hold-off, a full drain mid-run and several year-limit settings.
// ----------------------------------------------------------------------------
module datetime_string_validator_tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 190;
    localparam int BY_MODEL     = -1;
    localparam int TAIL_CYCLES  = 4;

    typedef logic [dtsv_pkg::CHAR_W-1:0] char_q_t[$];

    typedef struct {
        string text;
        int    want;
    } drill_row_t;

    // clock, reset and block ports
    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [dtsv_pkg::TDATA_IN_W-1:0]   s_tdata   = '0;   // [7:0] char_code
    logic                              s_tlast   = 1'b0; // line_end
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [dtsv_pkg::TDATA_OUT_W-1:0]  m_tdata;          // [0] valid_res, [7:1] zero
    logic                              cfg_wr_en = 1'b0;
    dtsv_pkg::cfg_idx_t                cfg_index = dtsv_pkg::CFG_YEAR_LOWEST;
    logic [dtsv_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    // bench copy of the record state and the year limits
    logic [dtsv_pkg::POS_W-1:0]   rec_pos;
    bit                           rec_clean;
    bit                           rec_told;
    logic [dtsv_pkg::YEAR_W-1:0]  acc_year;
    logic [dtsv_pkg::FIELD_W-1:0] acc_mon, acc_day, acc_hour, acc_min, acc_sec;
    logic [dtsv_pkg::YEAR_W-1:0]  lim_lo, lim_hi;

    // pending valid flags, oldest first, and typed flags of directed rows
    bit verdict_q[$];
    bit pinned_q[$];

    int mismatches    = 0;
    int results_seen  = 0;
    int valid_seen    = 0;
    int chars_taken   = 0;
    int cycles        = 0;
    int rx_hold_left  = 0;
    bit rx_steady     = 1'b0;
    bit tx_steady     = 1'b0;

    datetime_string_validator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int days_in(input int month, input int year);
        bit leap;
        leap = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
        case (month)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic void clear_record();
        rec_pos   = '0;
        rec_clean = 1'b1;
        rec_told  = 1'b0;
        acc_year  = '0;
        acc_mon   = '0;
        acc_day   = '0;
        acc_hour  = '0;
        acc_min   = '0;
        acc_sec   = '0;
    endfunction

    // what a record position holds, and the separator where it is one
    function automatic dtsv_pkg::slot_t slot_at(input logic [dtsv_pkg::POS_W-1:0] p,
                                                output logic [dtsv_pkg::CHAR_W-1:0] sep);
        sep = dtsv_pkg::CHAR_COLON;
        case (p)
            0, 1, 2, 3: return dtsv_pkg::SLOT_YEAR;
            5, 6:       return dtsv_pkg::SLOT_MONTH;
            8, 9:       return dtsv_pkg::SLOT_DAY;
            11, 12:     return dtsv_pkg::SLOT_HOUR;
            14, 15:     return dtsv_pkg::SLOT_MINUTE;
            17, 18:     return dtsv_pkg::SLOT_SECOND;
            4, 7: begin
                sep = dtsv_pkg::CHAR_DASH;
                return dtsv_pkg::SLOT_SEP;
            end
            10: begin
                sep = dtsv_pkg::CHAR_SPACE;
                return dtsv_pkg::SLOT_SEP;
            end
            default:    return dtsv_pkg::SLOT_SEP;
        endcase
    endfunction

    function automatic bit date_time_ok();
        if (!rec_clean) return 1'b0;
        if (acc_year < lim_lo || acc_year > lim_hi) return 1'b0;
        if (acc_mon < 1 || acc_mon > dtsv_pkg::MONTH_COUNT) return 1'b0;
        if (acc_hour > dtsv_pkg::HOUR_LAST || acc_min > dtsv_pkg::MINSEC_MAX ||
            acc_sec > dtsv_pkg::MINSEC_MAX) return 1'b0;
        return acc_day >= 1 && acc_day <= days_in(int'(acc_mon), int'(acc_year));
    endfunction

    // one accepted request: advance the record, tell whether a flag is due
    task automatic take_char(input logic [dtsv_pkg::CHAR_W-1:0] ch, input bit eol,
                             output bit gives, output bit verdict);
        dtsv_pkg::slot_t              sl;
        logic [dtsv_pkg::CHAR_W-1:0]  sep;
        logic [dtsv_pkg::DIGIT_W-1:0] dig;
        gives   = 1'b0;
        verdict = 1'b0;
        if (eol) begin
            gives = !rec_told;
            clear_record();
        end else if (!rec_told && rec_pos < dtsv_pkg::REC_LEN) begin
            sl = slot_at(rec_pos, sep);
            if (sl == dtsv_pkg::SLOT_SEP) begin
                if (ch != sep) rec_clean = 1'b0;
            end else if (ch < dtsv_pkg::CHAR_ZERO || ch > dtsv_pkg::CHAR_NINE) begin
                rec_clean = 1'b0;
            end else begin
                dig = dtsv_pkg::DIGIT_W'(ch - dtsv_pkg::CHAR_ZERO);
                case (sl)
                    dtsv_pkg::SLOT_YEAR:
                        acc_year = acc_year * 14'd10 + dtsv_pkg::YEAR_W'(dig);
                    dtsv_pkg::SLOT_MONTH:
                        acc_mon  = acc_mon  * 7'd10 + dtsv_pkg::FIELD_W'(dig);
                    dtsv_pkg::SLOT_DAY:
                        acc_day  = acc_day  * 7'd10 + dtsv_pkg::FIELD_W'(dig);
                    dtsv_pkg::SLOT_HOUR:
                        acc_hour = acc_hour * 7'd10 + dtsv_pkg::FIELD_W'(dig);
                    dtsv_pkg::SLOT_MINUTE:
                        acc_min  = acc_min  * 7'd10 + dtsv_pkg::FIELD_W'(dig);
                    default:
                        acc_sec  = acc_sec  * 7'd10 + dtsv_pkg::FIELD_W'(dig);
                endcase
            end
            rec_pos++;
            if (rec_pos == dtsv_pkg::REC_LEN) begin
                rec_told = 1'b1;
                gives    = 1'b1;
                verdict  = date_time_ok();
            end
        end
    endtask

    // watch both streams and the write port at every edge
    always @(posedge aclk) begin : watch
        bit gives;
        bit verdict;
        bit want;
        if (!aresetn) begin
            clear_record();
            lim_lo = dtsv_pkg::YEAR_LOWEST_RST;
            lim_hi = dtsv_pkg::YEAR_HIGHEST_RST;
            verdict_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    note_mismatch($sformatf("result 0x%02h with nothing pending", m_tdata));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata !== {{(dtsv_pkg::TDATA_OUT_W-1){1'b0}}, want})
                        note_mismatch($sformatf("record %0d: m_tdata 0x%02h, expected %0b",
                                                results_seen, m_tdata, want));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    dtsv_pkg::CFG_YEAR_LOWEST:  lim_lo = cfg_wdata;
                    dtsv_pkg::CFG_YEAR_HIGHEST: lim_hi = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                chars_taken++;
                take_char(s_tdata[dtsv_pkg::CHAR_W-1:0], s_tlast, gives, verdict);
                if (gives) begin
                    if (pinned_q.size() != 0) verdict = pinned_q.pop_front();
                    verdict_q.push_back(verdict);
                    if (verdict) valid_seen++;
                end
            end
        end
    end

    // receiver: random stalls, steady stretches and a counted hold-off
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, verdict_q.size());
            $display("** datetime_string_validator: FAILED **");
            $finish;
        end
    end

    task automatic put_item(input logic [dtsv_pkg::CHAR_W-1:0] ch, input bit eol);
        if (!tx_steady) begin
            while ($urandom_range(0, 99) < 10) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
    endtask

    // characters of a record, then the line end; returns the requests sent
    task automatic send_line(input char_q_t rec, output int counted);
        counted = rec.size() + 1;
        foreach (rec[i]) begin
            put_item(rec[i], 1'b0);
        end
        put_item(dtsv_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // stop sending and wait until the block has nothing left in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic set_year_limits(input int lo, input int hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= dtsv_pkg::CFG_YEAR_LOWEST;
        cfg_wdata <= dtsv_pkg::CFG_DATA_W'(lo);
        @(posedge aclk);
        cfg_index <= dtsv_pkg::CFG_YEAR_HIGHEST;
        cfg_wdata <= dtsv_pkg::CFG_DATA_W'(hi);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic char_q_t chars_of(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [dtsv_pkg::CHAR_W-1:0] odd_char();
        case ($urandom_range(0, 13))
            0:       return dtsv_pkg::CHAR_ZERO - 8'd1;
            1:       return dtsv_pkg::CHAR_NINE + 8'd1;
            2:       return dtsv_pkg::CHAR_DASH;
            3:       return dtsv_pkg::CHAR_SPACE;
            4:       return dtsv_pkg::CHAR_COLON;
            5:       return dtsv_pkg::CHAR_ZERO;
            6:       return dtsv_pkg::CHAR_NINE;
            default: return dtsv_pkg::CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed records around the limits, some broken, some noise
    function automatic char_q_t random_record();
        char_q_t q;
        int kind, n, y, mo, d, h, mi, se, dim;
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            n = $urandom_range(1, 25);
            repeat (n) q.push_back(dtsv_pkg::CHAR_W'($urandom_range(0, 255)));
            return q;
        end
        case ($urandom_range(0, 7))
            0:       y = int'(lim_lo);
            1:       y = int'(lim_hi);
            2:       y = int'(lim_lo) - 1;
            3:       y = int'(lim_hi) + 1;
            4: begin
                case ($urandom_range(0, 5))
                    0:       y = 0;
                    1:       y = 1900;
                    2:       y = 2000;
                    3:       y = 2100;
                    4:       y = 2024;
                    default: y = 2023;
                endcase
            end
            default: y = $urandom_range(0, 9999);
        endcase
        if (y < 0) y = 0;
        if (y > 9999) y = 9999;
        // month mostly in range, sometimes just outside or anywhere in 0..99
        case ($urandom_range(0, 19))
            0:       mo = 0;
            1:       mo = 13;
            2:       mo = $urandom_range(0, 99);
            3:       mo = 2;
            default: mo = $urandom_range(1, 12);
        endcase
        dim = (mo >= 1 && mo <= 12) ? days_in(mo, y) : 31;
        case ($urandom_range(0, 11))
            0:       d = 0;
            1:       d = 1;
            2:       d = dim;
            3:       d = dim + 1;
            4:       d = $urandom_range(0, 99);
            default: d = $urandom_range(1, dim);
        endcase
        case ($urandom_range(0, 11))
            0:       h = 23;
            1:       h = 24;
            2:       h = $urandom_range(0, 99);
            default: h = $urandom_range(0, 23);
        endcase
        case ($urandom_range(0, 11))
            0:       mi = 59;
            1:       mi = 60;
            2:       mi = $urandom_range(0, 99);
            default: mi = $urandom_range(0, 59);
        endcase
        case ($urandom_range(0, 11))
            0:       se = 59;
            1:       se = 60;
            2:       se = $urandom_range(0, 99);
            default: se = $urandom_range(0, 59);
        endcase
        q = chars_of($sformatf("%04d-%02d-%02d %02d:%02d:%02d", y, mo, d, h, mi, se));
        if (kind >= 70 && kind < 80) begin
            q[$urandom_range(0, dtsv_pkg::REC_LEN - 1)] = odd_char();
        end else if (kind >= 80 && kind < 88) begin
            n = $urandom_range(0, dtsv_pkg::REC_LEN - 1);
            while (q.size() > n) void'(q.pop_back());
        end else if (kind >= 88) begin
            n = $urandom_range(1, 5);
            repeat (n) q.push_back(dtsv_pkg::CHAR_W'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    // directed records, flag typed where it is plain to see
    drill_row_t drill[25] = '{
        '{"2000-01-01 00:00:00", 1},
        '{"9999-12-31 23:59:59", 1},
        '{"1999-12-31 23:59:59", 0},
        '{"2024-02-29 12:00:00", 1},
        '{"2023-02-29 12:00:00", 0},
        '{"2100-02-29 00:00:00", 0},
        '{"2000-02-29 00:00:00", 1},
        '{"2024-00-10 10:10:10", 0},
        '{"2024-13-10 10:10:10", 0},
        '{"2024-04-31 10:10:10", 0},
        '{"2024-04-30 10:10:10", 1},
        '{"2024-05-00 10:10:10", 0},
        '{"2024-05-05 24:00:00", 0},
        '{"2024-05-05 23:60:00", 0},
        '{"2024-05-05 23:00:60", 0},
        '{"2024-05-05 99:99:99", 0},
        '{"2024/05-05 10:10:10", 0},
        '{"2024-05-05T10:10:10", 0},
        '{"2024-0a-05 10:10:10", 0},
        '{"20:4-05-05 10:10:10", 0},
        '{"2024-05-05 10:10:1\377", 0},
        '{"2024-05-05 10:10", 0},
        '{"", 0},
        '{"2024-05-05 10:10:10 and more", 1},
        '{"2024-06-15 12:34:56", BY_MODEL}
    };

    initial begin : stimulus
        int phase_items;
        int counted;
        int lo, hi;
        int spin;
        bit held, paused;
        char_q_t rec;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed records under the reset limits
        foreach (drill[i]) begin
            if (drill[i].want != BY_MODEL) pinned_q.push_back(drill[i].want[0]);
            send_line(chars_of(drill[i].text), counted);
        end
        // line end right after a finished record, then an empty line
        send_line(chars_of(drill[0].text), counted);
        put_item(8'hFF, 1'b1);
        settle();

        // random records over several year-limit settings
        held   = 1'b0;
        paused = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin lo = 0;    hi = 9999; end
                1:       begin lo = 1900; hi = 2100; end
                2:       begin lo = 0;    hi = 0;    end
                3:       begin lo = 9999; hi = 9999; end
                4:       begin lo = 5000; hi = 1000; end
                5: begin
                    lo = $urandom_range(0, 9999);
                    hi = $urandom_range(lo, 9999);
                end
                default: begin lo = 2000; hi = 9999; end
            endcase
            set_year_limits(lo, hi);
            tx_steady = (ph == 3);
            rx_steady = (ph == 3);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                // long receiver hold-off while characters keep coming
                if (ph == 1 && !held && phase_items > 60) begin
                    rx_hold_left = 300;
                    held = 1'b1;
                end
                // full drain in the middle of a phase
                if (ph == 2 && !paused && phase_items > PHASE_ITEMS / 2) begin
                    settle();
                    paused = 1'b1;
                end
                rec = random_record();
                send_line(rec, counted);
                phase_items += counted;
                if ($urandom_range(0, 99) < 8) begin
                    put_item(dtsv_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
                    phase_items++;
                end
            end
            settle();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // wait for stragglers, bounded
        spin = 0;
        while (verdict_q.size() != 0 && spin < 2000) begin
            @(posedge aclk);
            spin++;
        end
        if (verdict_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        repeat (8) @(posedge aclk);

        $display("covered %0d character requests, %0d records checked (%0d valid)",
                 chars_taken, results_seen, valid_seen);
        $display("year limits: reset values plus %0d settings incl. zero, max and inverted",
                 PHASES);
        if (mismatches == 0) begin
            $display("** datetime_string_validator: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** datetime_string_validator: FAILED **");
        end
        $finish;
    end

endmodule
